// ===== rtl/pwt_pkg.sv =====
// Shared types and codes for the protobuf wire tokenizer.
// Holds the field layout widths, phase enum, event and error codes.
// No dependencies.
package pwt_pkg;

  localparam int unsigned MsgLenW   = 32;
  localparam int unsigned FieldW    = 32;
  localparam int unsigned WireW     = 3;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned KindW     = 3;
  localparam int unsigned ErrW      = 3;
  localparam int unsigned ShiftW    = 7;

  // Output tdata layout, lowest bit first.
  localparam int unsigned OutFieldsW = FieldW + WireW + ValueW + ByteW + 1 + ErrW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VALUE   = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_FIXED   = 3'd4
  } phase_t;

  typedef enum logic [KindW-1:0] {
    EV_PENDING = 3'd0,
    EV_TAG     = 3'd1,
    EV_VALUE   = 3'd2,
    EV_LENGTH  = 3'd3,
    EV_PAYLOAD = 3'd4,
    EV_FIXED   = 3'd5,
    EV_ERROR   = 3'd6,
    EV_IGNORED = 3'd7
  } event_t;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 3'd0,
    ERR_TOO_LONG  = 3'd1,
    ERR_BAD_WIRE  = 3'd2,
    ERR_PAST_END  = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_t;

  localparam logic [WireW-1:0] WIRE_VARINT = 3'd0;
  localparam logic [WireW-1:0] WIRE_FIX64  = 3'd1;
  localparam logic [WireW-1:0] WIRE_DELIM  = 3'd2;
  localparam logic [WireW-1:0] WIRE_FIX32  = 3'd5;

  localparam logic [MsgLenW-1:0] Fix64Bytes = 32'd8;
  localparam logic [MsgLenW-1:0] Fix32Bytes = 32'd4;
  localparam logic [ShiftW-1:0]  VarintStep = 7'd7;
  localparam logic [ShiftW-1:0]  ShiftLimit = 7'd64;

  typedef struct packed {
    logic [ErrW-1:0]   error_code;
    logic              field_done;
    logic [ByteW-1:0]  payload_byte;
    logic [ValueW-1:0] field_value;
    logic [WireW-1:0]  wire_kind;
    logic [FieldW-1:0] field_number;
  } out_fields_t;

endpackage

// ===== rtl/protobuf_wire_tokenizer.sv =====
// Streaming protobuf wire-format tokenizer: one result item per accepted input byte.
// Depends on pwt_pkg for field widths, phase enum, event and error codes.
//
//  channel  | dir | ports                              | payload
//  ---------+-----+------------------------------------+--------------------------------
//  in_      | in  | tvalid, tready, tdata[7:0]         | in_byte
//  out_     | out | tvalid, tready, tdata, tuser, tlast| token fields, event_kind, msg end
//  cfg_     | in  | wr_en, wr_data[31:0]               | message_length
//
// The decode of a byte is one pass of logic from the input handshake and the state
// registers into the result register.
// A new item is accepted each cycle while the result register is empty or is
// being drained in that same cycle (in_tready = !out_tvalid | out_tready).
// Reset (rst_n low, synchronous) returns to a fresh message start with
// message_length zero and the result register empty.
// A stall on the out_ side holds the result and the state; nothing is dropped.
module protobuf_wire_tokenizer
  import pwt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ByteW-1:0]     in_tdata,     // [7:0] in_byte
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [31:0] field_number, [34:32] wire_kind, [98:35] field_value,
  // [106:99] payload_byte, [107] field_done, [110:108] error_code, [111] zero
  output logic [OutDataW-1:0]  out_tdata,
  output logic [KindW-1:0]     out_tuser,    // [2:0] event_kind
  output logic                 out_tlast,    // message_done
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [MsgLenW-1:0]   cfg_wr_data   // message_length
);

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  logic [MsgLenW-1:0] msg_len_r;
  phase_t             phase_r,      phase_nxt;
  logic [ShiftW-1:0]  shift_cnt_r,  shift_cnt_nxt;
  logic [ValueW-1:0]  accum_r,      accum_nxt;
  logic [MsgLenW-1:0] left_r,       left_nxt;
  logic [MsgLenW-1:0] byte_pos_r,   byte_pos_nxt;
  logic [FieldW-1:0]  cur_field_r,  cur_field_nxt;
  logic [WireW-1:0]   cur_wire_r,   cur_wire_nxt;
  logic               err_seen_r,   err_seen_nxt;
  err_t               err_code_r,   err_code_nxt;

  // result register
  logic               out_valid_r;
  out_fields_t        out_fields_r, out_fields_nxt;
  event_t             out_kind_r,   out_kind_nxt;
  logic               out_last_r,   out_last_nxt;

  logic in_acc;

  // ---------------------------------------------------------------------------
  // Per-byte decode
  // ---------------------------------------------------------------------------
  logic               in_range;
  logic               is_last;
  logic [MsgLenW-1:0] remaining;
  logic [ValueW-1:0]  acc_or;
  logic [ShiftW-1:0]  shift_add;
  logic [MsgLenW-1:0] left_dec;
  logic               restart;
  event_t             kind;
  err_t               code;
  logic [ValueW-1:0]  val;
  logic [ByteW-1:0]   pbyte;
  logic               fdone;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign in_range  = byte_pos_r < msg_len_r;
  assign is_last   = byte_pos_r == (msg_len_r - 32'd1);
  assign remaining = msg_len_r - byte_pos_r - 32'd1;
  // shift counts below 64 are the only ones used; bits past bit 63 fall off
  assign acc_or    = accum_r | (ValueW'(in_tdata[6:0]) << shift_cnt_r[5:0]);
  assign shift_add = shift_cnt_r + VarintStep;
  assign left_dec  = left_r - 32'd1;

  always_comb begin
    phase_nxt     = phase_r;
    shift_cnt_nxt = shift_cnt_r;
    accum_nxt     = accum_r;
    left_nxt      = left_r;
    byte_pos_nxt  = byte_pos_r + 32'd1;
    cur_field_nxt = cur_field_r;
    cur_wire_nxt  = cur_wire_r;
    err_seen_nxt  = err_seen_r;
    err_code_nxt  = err_code_r;
    kind          = EV_IGNORED;
    code          = ERR_NONE;
    val           = '0;
    pbyte         = '0;
    fdone         = 1'b0;
    restart       = !in_range || is_last;

    if (!in_range) begin
      // byte beyond the message: report ignored, all other fields zero
      kind = EV_IGNORED;
    end else if (err_seen_r) begin
      // hold the sticky error until the message ends
      kind = EV_ERROR;
      code = err_code_r;
    end else begin
      case (phase_r)
        PH_TAG, PH_VALUE, PH_LENGTH: begin
          accum_nxt = acc_or;
          if (in_tdata[7]) begin
            shift_cnt_nxt = shift_add;
            if (shift_add >= ShiftLimit) begin
              code = ERR_TOO_LONG;
            end else if (is_last) begin
              code = ERR_TRUNCATED;
            end else begin
              kind = EV_PENDING;
            end
          end else begin
            accum_nxt     = '0;
            shift_cnt_nxt = '0;
            if (phase_r == PH_TAG) begin
              cur_field_nxt = acc_or[FieldW+2:3];
              cur_wire_nxt  = acc_or[WireW-1:0];
              kind          = EV_TAG;
              case (acc_or[WireW-1:0])
                WIRE_VARINT: begin
                  if (remaining == '0) code = ERR_TRUNCATED;
                  else phase_nxt = PH_VALUE;
                end
                WIRE_DELIM: begin
                  if (remaining == '0) code = ERR_TRUNCATED;
                  else phase_nxt = PH_LENGTH;
                end
                WIRE_FIX64: begin
                  if (remaining < Fix64Bytes) begin
                    code = ERR_PAST_END;
                  end else begin
                    left_nxt  = Fix64Bytes;
                    phase_nxt = PH_FIXED;
                  end
                end
                WIRE_FIX32: begin
                  if (remaining < Fix32Bytes) begin
                    code = ERR_PAST_END;
                  end else begin
                    left_nxt  = Fix32Bytes;
                    phase_nxt = PH_FIXED;
                  end
                end
                default: code = ERR_BAD_WIRE;
              endcase
            end else if (phase_r == PH_VALUE) begin
              kind      = EV_VALUE;
              val       = acc_or;
              fdone     = 1'b1;
              phase_nxt = PH_TAG;
            end else if (acc_or > ValueW'(remaining)) begin
              code = ERR_PAST_END;
            end else begin
              kind = EV_LENGTH;
              val  = acc_or;
              if (acc_or == '0) begin
                fdone     = 1'b1;
                phase_nxt = PH_TAG;
              end else begin
                left_nxt  = acc_or[MsgLenW-1:0];
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          if (code != ERR_NONE) begin
            kind         = EV_ERROR;
            val          = '0;
            fdone        = 1'b0;
            err_seen_nxt = 1'b1;
            err_code_nxt = code;
          end
        end
        PH_PAYLOAD, PH_FIXED: begin
          kind     = (phase_r == PH_PAYLOAD) ? EV_PAYLOAD : EV_FIXED;
          pbyte    = in_tdata;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            fdone     = 1'b1;
            phase_nxt = PH_TAG;
          end
        end
        default: begin
          phase_nxt = PH_TAG;
          kind      = EV_IGNORED;
        end
      endcase
    end

    // capture the result before a message restart clears the state
    out_kind_nxt                = kind;
    out_last_nxt                = in_range && is_last;
    out_fields_nxt.field_number = in_range ? cur_field_nxt : '0;
    out_fields_nxt.wire_kind    = in_range ? cur_wire_nxt  : '0;
    out_fields_nxt.field_value  = val;
    out_fields_nxt.payload_byte = pbyte;
    out_fields_nxt.field_done   = fdone;
    out_fields_nxt.error_code   = code;

    if (restart) begin
      phase_nxt     = PH_TAG;
      shift_cnt_nxt = '0;
      accum_nxt     = '0;
      left_nxt      = '0;
      byte_pos_nxt  = '0;
      cur_field_nxt = '0;
      cur_wire_nxt  = '0;
      err_seen_nxt  = 1'b0;
      err_code_nxt  = ERR_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r   <= '0;
      phase_r     <= PH_TAG;
      shift_cnt_r <= '0;
      accum_r     <= '0;
      left_r      <= '0;
      byte_pos_r  <= '0;
      cur_field_r <= '0;
      cur_wire_r  <= '0;
      err_seen_r  <= 1'b0;
      err_code_r  <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        msg_len_r <= cfg_wr_data;
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        shift_cnt_r <= shift_cnt_nxt;
        accum_r     <= accum_nxt;
        left_r      <= left_nxt;
        byte_pos_r  <= byte_pos_nxt;
        cur_field_r <= cur_field_nxt;
        cur_wire_r  <= cur_wire_nxt;
        err_seen_r  <= err_seen_nxt;
        err_code_r  <= err_code_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_fields_r <= out_fields_nxt;
      out_kind_r   <= out_kind_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OutDataW'(out_fields_r);
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_err_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == EV_ERROR) == (out_fields_r.error_code != ERR_NONE)))
    else $error("error code and error event disagree");

  a_value_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != EV_VALUE && out_kind_r != EV_LENGTH)
      |-> (out_fields_r.field_value == '0))
    else $error("field value set outside value or length event");

  a_ignored_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == EV_IGNORED)
      |-> (!out_last_r && out_fields_r.field_number == '0 && !out_fields_r.field_done))
    else $error("ignored event carries data");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_last_nxt) |=> (byte_pos_r == '0 && !err_seen_r && phase_r == PH_TAG))
    else $error("state not cleared after message end");

  a_sticky_error: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && err_seen_r && in_range) |-> (out_kind_nxt == EV_ERROR))
    else $error("error not sticky within message");

endmodule

// ===== tb/sv/pwt_tb_pkg.sv =====
// Token prediction and checking for the protobuf wire tokenizer testbench.
// Holds the expected-token type and the token_ledger class; depends on pwt_pkg.
package pwt_tb_pkg;
  import pwt_pkg::*;

  typedef struct packed {
    event_t      kind;
    logic        is_last;
    out_fields_t f;
  } token_t;

  class token_ledger;
    token_t      tokens_due[$];
    int unsigned mismatches;

    logic [MsgLenW-1:0] msg_length;
    phase_t             cur_phase;
    logic [ShiftW-1:0]  shift_bits;
    logic [ValueW-1:0]  accum_value;
    logic [MsgLenW-1:0] field_bytes_left;
    logic [MsgLenW-1:0] msg_pos;
    logic [FieldW-1:0]  tag_field;
    logic [WireW-1:0]   tag_wire;
    logic               err_sticky;
    err_t               err_held;

    function new();
      mismatches = 0;
      msg_length = '0;
      fresh_message();
    endfunction

    function void fresh_message();
      cur_phase        = PH_TAG;
      shift_bits       = '0;
      accum_value      = '0;
      field_bytes_left = '0;
      msg_pos          = '0;
      tag_field        = '0;
      tag_wire         = '0;
      err_sticky       = 1'b0;
      err_held         = ERR_NONE;
    endfunction

    function void set_length(logic [MsgLenW-1:0] len);
      msg_length = len;
    endfunction

    function int unsigned due_count();
      return tokens_due.size();
    endfunction

    // Work out the token that one accepted byte produces and queue it.
    function void note_byte(logic [ByteW-1:0] b);
      token_t             t;
      logic [MsgLenW-1:0] rest;
      logic [ValueW-1:0]  v;
      err_t               code;
      t    = '0;
      code = ERR_NONE;
      if (msg_pos >= msg_length) begin
        t.kind = EV_IGNORED;
        tokens_due.push_back(t);
        fresh_message();
        return;
      end
      t.is_last = (msg_pos == msg_length - 1);
      rest      = msg_length - msg_pos - 1;
      t.kind    = EV_IGNORED;
      if (err_sticky) begin
        t.kind = EV_ERROR;
        code   = err_held;
      end else if (cur_phase == PH_TAG || cur_phase == PH_VALUE || cur_phase == PH_LENGTH) begin
        accum_value |= {57'b0, b[6:0]} << shift_bits[5:0];
        if (b[7]) begin
          shift_bits += VarintStep;
          if (shift_bits >= ShiftLimit) code = ERR_TOO_LONG;
          else if (t.is_last) code = ERR_TRUNCATED;
          else t.kind = EV_PENDING;
        end else begin
          v           = accum_value;
          accum_value = '0;
          shift_bits  = '0;
          if (cur_phase == PH_TAG) begin
            tag_field = v[FieldW+2:3];
            tag_wire  = v[2:0];
            t.kind    = EV_TAG;
            case (tag_wire)
              WIRE_VARINT: if (rest == 0) code = ERR_TRUNCATED; else cur_phase = PH_VALUE;
              WIRE_DELIM:  if (rest == 0) code = ERR_TRUNCATED; else cur_phase = PH_LENGTH;
              WIRE_FIX64: begin
                if (rest < Fix64Bytes) code = ERR_PAST_END;
                else begin
                  field_bytes_left = Fix64Bytes;
                  cur_phase        = PH_FIXED;
                end
              end
              WIRE_FIX32: begin
                if (rest < Fix32Bytes) code = ERR_PAST_END;
                else begin
                  field_bytes_left = Fix32Bytes;
                  cur_phase        = PH_FIXED;
                end
              end
              default: code = ERR_BAD_WIRE;
            endcase
          end else if (cur_phase == PH_VALUE) begin
            t.kind          = EV_VALUE;
            t.f.field_value = v;
            t.f.field_done  = 1'b1;
            cur_phase       = PH_TAG;
          end else if (v > {32'b0, rest}) begin
            code = ERR_PAST_END;
          end else begin
            t.kind          = EV_LENGTH;
            t.f.field_value = v;
            if (v == 0) begin
              t.f.field_done = 1'b1;
              cur_phase      = PH_TAG;
            end else begin
              field_bytes_left = v[MsgLenW-1:0];
              cur_phase        = PH_PAYLOAD;
            end
          end
        end
        if (code != ERR_NONE) begin
          t.kind          = EV_ERROR;
          t.f.field_value = '0;
          t.f.field_done  = 1'b0;
          err_sticky      = 1'b1;
          err_held        = code;
        end
      end else begin
        if (cur_phase == PH_PAYLOAD) t.kind = EV_PAYLOAD;
        else t.kind = EV_FIXED;
        t.f.payload_byte = b;
        field_bytes_left -= 1;
        if (field_bytes_left == 0) begin
          t.f.field_done = 1'b1;
          cur_phase      = PH_TAG;
        end
      end
      msg_pos += 1;
      t.f.field_number = tag_field;
      t.f.wire_kind    = tag_wire;
      t.f.error_code   = code;
      tokens_due.push_back(t);
      if (t.is_last) fresh_message();
    endfunction

    function void same(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted result item against the oldest queued token.
    function void check_token(logic [KindW-1:0] kind, logic [OutDataW-1:0] data, logic last);
      token_t      want;
      out_fields_t got;
      got = out_fields_t'(data[OutFieldsW-1:0]);
      if (tokens_due.size() == 0) begin
        $error("event_kind: expected none, actual %0h", kind);
        mismatches++;
        return;
      end
      want = tokens_due.pop_front();
      same("event_kind", want.kind, kind);
      same("field_number", want.f.field_number, got.field_number);
      same("wire_kind", want.f.wire_kind, got.wire_kind);
      same("field_value", want.f.field_value, got.field_value);
      same("payload_byte", want.f.payload_byte, got.payload_byte);
      same("field_done", want.f.field_done, got.field_done);
      same("message_done", want.is_last, last);
      same("error_code", want.f.error_code, got.error_code);
      same("tdata_pad", '0, data[OutDataW-1:OutFieldsW]);
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
// Top-level testbench for protobuf_wire_tokenizer: directed and random messages.
// Depends on pwt_pkg for widths and codes and on pwt_tb_pkg for the token ledger.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwt_pkg::*;
  import pwt_tb_pkg::*;

  // Wire types with no field layout of their own: groups and the reserved codes.
  localparam logic [WireW-1:0] WIRE_SGROUP = 3'd3;
  localparam logic [WireW-1:0] WIRE_EGROUP = 3'd4;
  localparam logic [WireW-1:0] WIRE_RSVD6  = 3'd6;
  localparam logic [WireW-1:0] WIRE_RSVD7  = 3'd7;

  localparam int unsigned ByteTarget = 1950;
  localparam int unsigned StallLimit = 1000;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic [KindW-1:0]    out_tuser;
  logic                out_tlast;
  logic                cfg_wr_en;
  logic [MsgLenW-1:0]  cfg_wr_data;

  token_ledger      book;
  logic [ByteW-1:0] msg[$];     // bytes of the message being built
  logic             idle_on;    // random gaps and stalls allowed
  int unsigned      sent;       // bytes sent inside a message

  protobuf_wire_tokenizer u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Message building
  // ---------------------------------------------------------------------------

  // Append v as a base-128 varint, low group first.
  function automatic void push_varint(logic [63:0] v);
    logic [63:0] rest;
    rest = v;
    do begin
      msg.push_back({rest[63:7] != 0, rest[6:0]});
      rest = rest >> 7;
    end while (rest != 0);
  endfunction

  // Spread values over all widths so short and ten-byte varints both show up.
  function automatic logic [63:0] rand_value();
    return {$urandom, $urandom} >> $urandom_range(0, 64);
  endfunction

  function automatic logic [FieldW-1:0] rand_field();
    return 32'($urandom) >> $urandom_range(0, 31);
  endfunction

  // Append a tag; now and then set bits above the 32-bit field number,
  // which the block must drop.
  function automatic void add_tag(logic [FieldW-1:0] fnum, logic [WireW-1:0] wk);
    logic [63:0] tag;
    tag = {29'b0, fnum, wk};
    if ($urandom_range(0, 15) == 0) tag[63:35] = 29'($urandom);
    push_varint(tag);
  endfunction

  // Build a message of 1 to 4 fields: mostly well-formed, some broken ones.
  function automatic void build_message();
    int unsigned pick;
    int unsigned n;
    logic [WireW-1:0] odd_wire;
    msg.delete();
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        add_tag(rand_field(), WIRE_VARINT);
        push_varint(rand_value());
      end else if (pick < 50) begin
        add_tag(rand_field(), WIRE_DELIM);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        push_varint(64'(n));
        repeat (n) msg.push_back(8'($urandom));
      end else if (pick < 65) begin
        add_tag(rand_field(), WIRE_FIX32);
        repeat (4) msg.push_back(8'($urandom));
      end else if (pick < 80) begin
        add_tag(rand_field(), WIRE_FIX64);
        repeat (8) msg.push_back(8'($urandom));
      end else if (pick < 84) begin
        // group or reserved wire type
        case ($urandom_range(0, 3))
          0:       odd_wire = WIRE_SGROUP;
          1:       odd_wire = WIRE_EGROUP;
          2:       odd_wire = WIRE_RSVD6;
          default: odd_wire = WIRE_RSVD7;
        endcase
        add_tag(rand_field(), odd_wire);
      end else if (pick < 88) begin
        // overlong varint in tag position
        repeat ($urandom_range(10, 12)) msg.push_back(8'($urandom) | 8'h80);
        msg.push_back(8'($urandom) & 8'h7f);
      end else if (pick < 92) begin
        // ten-byte value whose last byte carries bits past bit 63
        add_tag(rand_field(), WIRE_VARINT);
        repeat (9) msg.push_back(8'($urandom) | 8'h80);
        msg.push_back(8'($urandom) & 8'h7f);
      end else if (pick < 96) begin
        // length with no payload behind it
        add_tag(rand_field(), WIRE_DELIM);
        push_varint(rand_value() | 64'h100);
      end else begin
        repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte, with an optional gap first; hold valid until accepted.
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    book.note_byte(b);
  endtask

  // Write message_length only once the block has drained every token.
  task automatic write_length(input logic [MsgLenW-1:0] len);
    in_tvalid <= 1'b0;
    while (book.due_count() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    book.set_length(len);
    cfg_wr_en <= 1'b0;
  endtask

  // Set the length, then send n bytes: msg first, random filler after it.
  task automatic play(input logic [MsgLenW-1:0] len, input int unsigned n);
    write_length(len);
    for (int unsigned i = 0; i < n; i++) begin
      if (i < msg.size()) send_byte(msg[i]);
      else send_byte(8'($urandom));
    end
    if (len != 0) sent += n;
  endtask

  // Result side: ready runs, broken by stall bursts while idling is on.
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 1) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Check every accepted result item against the ledger.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_token(out_tuser, out_tdata, out_tlast);
  end

  // Abort when no handshake and no register write happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned len;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    idle_on     = 1'b1;
    sent        = 0;
    book        = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero length, so the byte is ignored.
    msg = '{8'hff};
    play(0, 1);
    // Varint field, 0x7f.
    msg = '{8'h08, 8'h7f};
    play(2, 2);
    // Empty delimited field ends on its length byte.
    msg = '{8'h12, 8'h00};
    play(2, 2);
    // Delimited field with one payload byte.
    msg = '{8'h12, 8'h01, 8'hab};
    play(3, 3);
    // Fixed32 with too few bytes left, then the sticky error.
    msg = '{8'h0d, 8'h55};
    play(2, 2);
    // Start-group wire type.
    msg = '{8'h0b};
    play(1, 1);
    // Varint cut off by the end of the message.
    msg = '{8'h08, 8'h80};
    play(2, 2);
    // Length larger than what is left.
    msg = '{8'h12, 8'h05, 8'h00};
    play(3, 3);
    // Largest length, value varint with a continuation bit on its tenth byte.
    msg = '{8'h10, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
            8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
    play(32'hffff_ffff, 11);
    // Shrink the length below the position reached: ignored, then restart.
    msg.delete();
    play(1, 1);

    // Random messages; drop idling for the last tenth.
    while (sent < ByteTarget) begin
      if (sent > ByteTarget * 9 / 10) idle_on = 1'b0;
      build_message();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        play(msg.size(), msg.size());
      end else if (pick < 80) begin
        len = $urandom_range(1, msg.size());
        play(len, len);
      end else if (pick < 87) begin
        len = msg.size() + $urandom_range(1, 6);
        play(len, len);
      end else if (pick < 93) begin
        msg.delete();
        len = $urandom_range(1, 24);
        play(len, len);
      end else if (pick < 97) begin
        // open-ended message; the next length write lands mid-message
        play(32'hffff_ffff, msg.size());
      end else begin
        msg.delete();
        write_length(0);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end

    // Drain, then let the last result settle.
    idle_on = 1'b0;
    in_tvalid <= 1'b0;
    while (book.due_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pwt_pkg.sv
rtl/protobuf_wire_tokenizer.sv
tb/sv/pwt_tb_pkg.sv
tb/sv/tb.sv
